// ===== hdl/swmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared widths, types and state codes for the sliding window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int WINDOW_MAX = 64;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int FILL_W     = $clog2(WINDOW_MAX + 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] hi;
    logic signed [SAMPLE_W-1:0] lo;
  } minmax_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/sliding_window_min_max_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_min_max_top
// Streaming minimum and maximum over the last window_size samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed sample per beat in tdata; tuser set marks the
//   first sample of a new sequence and clears the fill count.
//   m_axis gives {window_max, window_min} for each sample once the current
//   sequence holds at least window_size samples; earlier samples give none.
//   cfg writes window_size (0 acts as 1, above 64 acts as 64); cfg_ready is
//   low during a scan; write only while idle.
// Timing:
//   Accepting a sample shifts it into a row of 64 cells. When a result is
//   due, the running min/max walks the row one cell per cycle, so the result
//   reaches the output register at the end of the walk, and the input
//   reopens as the result is loaded. A sample without a result leaves the
//   input open for the next sample. The 64-cell walk sets the rate.
// Reset / stall:
//   rst clears the fill count, sets window_size to 1, drops m_axis_tvalid and
//   holds s_axis_tready and cfg_ready low. A stalled output beat is held in
//   its register; the next sample is still taken and scanned, and waits for
//   the register to free before leaving.
// ----------------------------------------------------------------------------
module sliding_window_min_max_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [swmm_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [31:0] sample
  input  logic                           s_axis_tuser,   // [0] first
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [2*swmm_pkg::SAMPLE_W-1:0] m_axis_tdata,  // [31:0] window_min,
                                                         // [63:32] window_max
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swmm_pkg::FILL_W-1:0]    cfg_data        // window_size
);
  import swmm_pkg::*;

  state_t             state, state_next;
  logic [FILL_W-1:0]  window_size;
  logic [FILL_W-1:0]  fill_count, fill_count_next;
  logic [FILL_W-1:0]  eff_size;
  logic [IDX_W-1:0]   cnt, cnt_next;
  logic               out_valid, out_valid_next;
  minmax_t            out_data;
  logic               in_beat, out_free, load_out;

  logic signed [SAMPLE_W-1:0] samples [WINDOW_MAX];
  minmax_t                    accs    [WINDOW_MAX];

  // the window size feeds the cell enables, so it only moves between scans
  assign cfg_ready     = !rst && (state == ST_IDLE);
  assign s_axis_tready = !rst && (state == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_data.hi, out_data.lo};

  always_comb begin
    if (window_size == '0) begin
      eff_size = FILL_W'(1);
    end else if (window_size > FILL_W'(WINDOW_MAX)) begin
      eff_size = FILL_W'(WINDOW_MAX);
    end else begin
      eff_size = window_size;
    end
  end

  // row of cells; cell 0 holds the newest sample and seeds the scan
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] cell_in;
    minmax_t                    cell_acc_in;
    if (i == 0) begin : g_head
      assign cell_in     = $signed(s_axis_tdata);
      assign cell_acc_in = '{hi: samples[0], lo: samples[0]};
    end else begin : g_body
      assign cell_in     = samples[i-1];
      assign cell_acc_in = accs[i-1];
    end
    swmm_cell u_cell (
      .clk      (clk),
      .shift    (in_beat),
      .active   (FILL_W'(i) < eff_size),
      .sample_in(cell_in),
      .acc_in   (cell_acc_in),
      .sample_q (samples[i]),
      .acc_q    (accs[i])
    );
  end

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    cnt_next        = cnt;
    load_out        = 1'b0;
    out_valid_next  = out_valid && !m_axis_tready;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          if (s_axis_tuser) begin
            fill_count_next = FILL_W'(1);
          end else if (fill_count < FILL_W'(WINDOW_MAX)) begin
            fill_count_next = fill_count + FILL_W'(1);
          end
          if (fill_count_next >= eff_size) begin
            state_next = ST_SCAN;
            cnt_next   = '0;
          end
        end
      end
      ST_SCAN: begin
        cnt_next = cnt + IDX_W'(1);
        if (cnt == IDX_W'(WINDOW_MAX - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_count  <= '0;
      window_size <= FILL_W'(1);
      out_valid   <= 1'b0;
      cnt         <= '0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      out_valid  <= out_valid_next;
      cnt        <= cnt_next;
      if (cfg_valid && cfg_ready) begin
        window_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= accs[WINDOW_MAX-1];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/swmm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_cell
// One window position: holds a sample and folds it into the running min/max
// that moves one cell down the row per cycle.
// ----------------------------------------------------------------------------
module swmm_cell (
  input  logic                                 clk,
  input  logic                                 shift,
  input  logic                                 active,
  input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample_in,
  input  swmm_pkg::minmax_t                    acc_in,
  output logic signed [swmm_pkg::SAMPLE_W-1:0] sample_q,
  output swmm_pkg::minmax_t                    acc_q
);
  import swmm_pkg::*;

  minmax_t acc_next;

  always_comb begin
    acc_next = acc_in;
    if (active) begin
      if (sample_q < acc_in.lo) begin
        acc_next.lo = sample_q;
      end
      if (sample_q > acc_in.hi) begin
        acc_next.hi = sample_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      sample_q <= sample_in;
    end
    acc_q <= acc_next;
  end

endmodule
`default_nettype wire

// ===== hdl/swmm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_checker
// Port-level checks for the sliding window min/max block.
// ----------------------------------------------------------------------------
module swmm_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [swmm_pkg::SAMPLE_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [2*swmm_pkg::SAMPLE_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [swmm_pkg::FILL_W-1:0]     cfg_data
);
  import swmm_pkg::*;

  logic signed [SAMPLE_W-1:0] chk_min, chk_max;
  assign chk_min = $signed(m_axis_tdata[SAMPLE_W-1:0]);
  assign chk_max = $signed(m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> chk_min <= chk_max)
    else $error("window minimum above maximum");

  // a result only appears at the end of a scan, when input is closed
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a completed scan");

endmodule

bind sliding_window_min_max_top swmm_checker u_swmm_checker (.*);
`default_nettype wire

// ===== tb/sliding_window_min_max_top_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_min_max_top_test
// Self-checking bench for the streaming window min/max block.
// A short directed table covers sample extremes, the reset window size,
// sizes 0, 65 and 127, size changes mid-sequence, sequence restarts and ties.
// Random phases follow under varied window sizes and handshake idling,
// including one long output stall. Every result beat is compared with
// the table's expected values or a local predictor of the window contents.
// ----------------------------------------------------------------------------
module sliding_window_min_max_top_test;

  import swmm_pkg::*;

  localparam int DRAIN_CYCLES = 80;    // outlasts the scan from an accept to its result
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 110;

  typedef struct {
    int                  size_wr;      // < 0: no register write before the row
    logic [SAMPLE_W-1:0] sample;
    bit                  first;
    bit                  typed;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [SAMPLE_W-1:0]     s_axis_tdata = '0;  // [31:0] sample
  logic                    s_axis_tuser = 1'b0; // [0] first
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [2*SAMPLE_W-1:0]   m_axis_tdata;       // [31:0] window_min, [63:32] window_max
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [FILL_W-1:0]       cfg_data = '0;      // window_size

  // predictor state
  logic signed [SAMPLE_W-1:0] history [WINDOW_MAX];
  int                         fill_level = 0;
  logic [FILL_W-1:0]          size_setting = FILL_W'(1);

  minmax_t expected_extremes[$];

  int  source_idle_pct = 0;
  int  sink_idle_pct   = 0;
  bit  hold_request    = 1'b0;
  int  hold_left       = 0;
  int  quiet_cycles    = 0;
  int  mismatches      = 0;
  int  samples_sent    = 0;
  int  windows_seen    = 0;
  int  sizes_written   = 0;

  stim_row_t directed_rows [19] = '{
    '{-1, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000},
    '{-1, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{-1, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{-1, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{ 0, 32'h0000_0005, 1'b0, 1'b1, 32'h0000_0005, 32'h0000_0005},
    '{-1, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000},
    '{ 3, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 32'h0},
    '{-1, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{-1, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 32'h0},
    '{-1, 32'hFFFF_FFF9, 1'b0, 1'b0, 32'h0, 32'h0},
    '{-1, 32'h0000_0064, 1'b1, 1'b0, 32'h0, 32'h0},
    '{-1, 32'h0000_0064, 1'b0, 1'b0, 32'h0, 32'h0},
    '{-1, 32'h0000_0064, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ 2, 32'h0000_0032, 1'b0, 1'b0, 32'h0, 32'h0},
    '{127, 32'h0000_0009, 1'b1, 1'b0, 32'h0, 32'h0},
    '{65, 32'hFFFF_FFF7, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ 4, 32'h0000_0003, 1'b0, 1'b0, 32'h0, 32'h0},
    '{-1, 32'h0000_0002, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ 1, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF}
  };

  // 0 and 127 exercise the size clamps; -1 picks a random size
  int phase_sizes [PHASES] = '{64, 5, 127, 2, 0, 13, 1, -1, 64, 3};

  sliding_window_min_max_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int window_len();
    if (size_setting == 0) return 1;
    if (size_setting > WINDOW_MAX) return WINDOW_MAX;
    return int'(size_setting);
  endfunction

  // shifts one sample in; returns 1 with the extremes when a window is due
  function automatic bit slide_window(input logic signed [SAMPLE_W-1:0] s, input bit first,
                                      output minmax_t r);
    int k;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    k = window_len();
    if (first) fill_level = 0;
    for (int i = WINDOW_MAX - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = s;
    if (fill_level < WINDOW_MAX) fill_level++;
    r = '0;
    if (fill_level < k) return 1'b0;
    lo = history[0];
    hi = history[0];
    for (int i = 1; i < k; i++) begin
      if (history[i] < lo) lo = history[i];
      if (history[i] > hi) hi = history[i];
    end
    r.lo = lo;
    r.hi = hi;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, $signed(want), $signed(got));
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit first, input bit typed,
                             input minmax_t typed_r);
    int      gap;
    minmax_t r;
    gap = 0;
    while ($urandom_range(99) < source_idle_pct && gap < 50) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    s_axis_tuser  <= first;
    do @(posedge clk); while (!s_axis_tready);
    samples_sent++;
    if (slide_window(s, first, r)) expected_extremes.push_back(typed ? typed_r : r);
  endtask

  // register writes only once the block has gone quiet
  task automatic set_window(input logic [FILL_W-1:0] size);
    s_axis_tvalid <= 1'b0;
    while (expected_extremes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_setting = size;
    sizes_written++;
  endtask

  task automatic check_window(input minmax_t got);
    minmax_t want;
    windows_seen++;
    if (expected_extremes.size() == 0) begin
      flag_mismatch("unexpected beat, window_min", '0, got.lo);
    end else begin
      want = expected_extremes.pop_front();
      if (got.lo !== want.lo) flag_mismatch("window_min", want.lo, got.lo);
      if (got.hi !== want.hi) flag_mismatch("window_max", want.hi, got.hi);
    end
  endtask

  // result side, with its own long hold-off counter
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_window(minmax_t'(m_axis_tdata));
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    minmax_t             no_value;
    logic [SAMPLE_W-1:0] s;
    logic [FILL_W-1:0]   size;
    bit                  first;
    int                  restart_odds;
    no_value = '0;
    foreach (history[i]) history[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    source_idle_pct = 36;
    sink_idle_pct   = 66;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].size_wr >= 0) set_window(directed_rows[i].size_wr[FILL_W-1:0]);
      send_sample(directed_rows[i].sample, directed_rows[i].first, directed_rows[i].typed,
                  '{hi: directed_rows[i].hi, lo: directed_rows[i].lo});
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        source_idle_pct = 66;
        sink_idle_pct   = 36;
      end else if (p == 7) begin
        source_idle_pct = 0;
        sink_idle_pct   = 0;
      end
      size = (phase_sizes[p] < 0) ? FILL_W'($urandom_range(127)) : FILL_W'(phase_sizes[p]);
      set_window(size);
      restart_odds = (window_len() > 16) ? 300 : 40;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(9))
          0:       s = 32'h8000_0000;
          1:       s = 32'h7FFF_FFFF;
          2, 3:    s = SAMPLE_W'($urandom_range(20)) - 32'd10;  // small values, many ties
          default: s = $urandom;
        endcase
        first = (n == 0) ? ($urandom_range(1) == 1) :
                           ($urandom_range(restart_odds - 1) == 0);
        // output held off while the source keeps offering: the input must back up
        if (p == 8 && n == 20) hold_request = 1'b1;
        send_sample(s, first, 1'b0, no_value);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_extremes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_extremes.size();

    $display("Covered %0d samples under %0d window size writes (0, 1..64, 65, 127),",
             samples_sent, sizes_written);
    $display("%0d windows checked, with source/sink idling and one long output stall.",
             windows_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
